// File: sv/i2cm_pkg.sv
// shared types and constants for the i2c register access master
// no dependencies; used by the interfaces, core, output stage and top level
`default_nettype none

package i2cm_pkg;

  localparam int MAX_BURST = 16;
  localparam int BURST_W   = $clog2(MAX_BURST + 1);

  localparam int BITS_PER_BYTE = 8;
  localparam logic [7:0] MSB_MASK = 8'h80;
  localparam logic [7:0] READ_BIT = 8'h01;

  localparam logic [6:0]  DEVICE_ADDRESS_RST = 7'd104;
  localparam logic [15:0] HALF_PERIOD_RST    = 16'd50;

  // command codes
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD    = 1'd1;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_A,
    PH_START_B,
    PH_TX_LO,
    PH_TX_HI,
    PH_TACK_LO,
    PH_TACK_HI,
    PH_RX_LO,
    PH_RX_HI,
    PH_MACK_LO,
    PH_MACK_HI,
    PH_RS_LO,
    PH_STOP_LO,
    PH_STOP_HI,
    PH_STOP_END
  } phase_t;

  typedef enum logic [1:0] {
    ST_ADDR_W,
    ST_REG,
    ST_DATA,
    ST_ADDR_R
  } stage_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [4:0] read_count;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic        scl_out;
    logic        sda_out;
    logic        busy_res;
    logic        byte_valid;
    logic [7:0]  read_byte;
    logic        word_valid;
    logic [15:0] read_word;
    logic        ack_bit;
    logic        last_byte;
  } res_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;
  } cfg_t;

endpackage

`default_nettype wire

// File: sv/i2cm_cmd_if.sv
// command channel: valid/ready handshake carrying one tick's input word
// depends on i2cm_pkg
`default_nettype none

interface i2cm_cmd_if;
  logic              valid;
  logic              ready;
  i2cm_pkg::cmd_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/i2cm_res_if.sv
// result channel: valid/ready handshake carrying one tick's output word
// depends on i2cm_pkg
`default_nettype none

interface i2cm_res_if;
  logic              valid;
  logic              ready;
  i2cm_pkg::res_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/i2cm_cfg_if.sv
// configuration write channel: register index and write data
// depends on i2cm_pkg
`default_nettype none

interface i2cm_cfg_if;
  logic              valid;
  logic              ready;
  i2cm_pkg::cfg_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/i2cm_core.sv
// bus sequencer: advances the i2c state by one tick per accepted word
// and forms that tick's result word; depends on i2cm_pkg
`default_nettype none

module i2cm_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            acc,
  input  wire i2cm_pkg::cmd_t  cmd,
  input  wire logic [6:0]      device_address,
  input  wire logic [15:0]     half_period_ticks,
  output i2cm_pkg::res_t       res
);
  import i2cm_pkg::*;

  phase_t             phase, phase_next;
  stage_t             stage, stage_next;
  logic [15:0]        tick_count, tick_count_next;
  logic [3:0]         bit_count, bit_count_next;
  logic [7:0]         shift_reg, shift_reg_next;
  logic [BURST_W-1:0] bytes_left, bytes_left_next;
  logic [7:0]         held_high_byte, held_high_byte_next;
  logic [1:0]         cmd_mode, cmd_mode_next;
  logic [7:0]         cmd_reg, cmd_reg_next;
  logic [7:0]         cmd_low, cmd_low_next;
  logic               ack_held, ack_held_next;

  logic               rx_done;
  logic               rx_odd;
  logic [15:0]        tick_inc;
  logic [3:0]         bit_inc;
  logic [4:0]         rc_sat;
  logic [7:0]         addr_byte;

  assign tick_inc  = tick_count + 16'd1;
  assign bit_inc   = bit_count + 4'd1;
  assign addr_byte = {device_address, 1'b0};

  always_comb begin
    rc_sat = cmd.read_count;
    if (rc_sat == 5'd0) begin
      rc_sat = 5'd1;
    end
    if (32'(rc_sat) > MAX_BURST) begin
      rc_sat = 5'(MAX_BURST);
    end
  end

  // next state
  always_comb begin
    phase_next          = phase;
    stage_next          = stage;
    tick_count_next     = tick_count;
    bit_count_next      = bit_count;
    shift_reg_next      = shift_reg;
    bytes_left_next     = bytes_left;
    held_high_byte_next = held_high_byte;
    cmd_mode_next       = cmd_mode;
    cmd_reg_next        = cmd_reg;
    cmd_low_next        = cmd_low;
    ack_held_next       = ack_held;
    rx_done             = 1'b0;
    rx_odd              = 1'b0;

    if (phase == PH_IDLE) begin
      if (cmd.mode == MODE_WRITE || cmd.mode == MODE_READ) begin
        cmd_mode_next = cmd.mode;
        cmd_reg_next  = cmd.reg_addr;
        cmd_low_next  = cmd.write_data;
        if (cmd.mode == MODE_READ) begin
          cmd_low_next    = 8'(rc_sat);
          bytes_left_next = BURST_W'(rc_sat);
        end
        stage_next      = ST_ADDR_W;
        phase_next      = PH_START_A;
        tick_count_next = 16'd0;
      end
    end else begin
      tick_count_next = tick_inc;
      if (tick_inc >= half_period_ticks) begin
        tick_count_next = 16'd0;
        case (phase)
          PH_START_A: phase_next = PH_START_B;
          PH_START_B: begin
            shift_reg_next = (stage == ST_ADDR_R) ? (addr_byte | READ_BIT) : addr_byte;
            bit_count_next = 4'd0;
            phase_next     = PH_TX_LO;
          end
          PH_TX_LO: phase_next = PH_TX_HI;
          PH_TX_HI: begin
            shift_reg_next = {shift_reg[6:0], 1'b0};
            bit_count_next = bit_inc;
            phase_next     = (32'(bit_inc) >= BITS_PER_BYTE) ? PH_TACK_LO : PH_TX_LO;
          end
          PH_TACK_LO: phase_next = PH_TACK_HI;
          PH_TACK_HI: begin
            ack_held_next = cmd.sda_in;
            case (stage)
              ST_ADDR_W: begin
                stage_next     = ST_REG;
                shift_reg_next = cmd_reg;
                bit_count_next = 4'd0;
                phase_next     = PH_TX_LO;
              end
              ST_REG: begin
                if (cmd_mode == MODE_WRITE) begin
                  stage_next     = ST_DATA;
                  shift_reg_next = cmd_low;
                  bit_count_next = 4'd0;
                  phase_next     = PH_TX_LO;
                end else begin
                  phase_next = PH_RS_LO;
                end
              end
              ST_DATA: phase_next = PH_STOP_LO;
              default: begin
                shift_reg_next = 8'd0;
                bit_count_next = 4'd0;
                phase_next     = PH_RX_LO;
              end
            endcase
          end
          PH_RS_LO: begin
            stage_next = ST_ADDR_R;
            phase_next = PH_START_A;
          end
          PH_RX_LO: phase_next = PH_RX_HI;
          PH_RX_HI: begin
            shift_reg_next = {shift_reg[6:0], cmd.sda_in};
            bit_count_next = bit_inc;
            if (32'(bit_inc) >= BITS_PER_BYTE) begin
              rx_done = 1'b1;
              // byte index parity: burst length minus bytes still to come
              rx_odd  = cmd_low[0] ^ bytes_left[0];
              if (!rx_odd) begin
                held_high_byte_next = shift_reg_next;
              end
              if (bytes_left != '0) begin
                bytes_left_next = bytes_left - BURST_W'(1);
              end
              phase_next = PH_MACK_LO;
            end else begin
              phase_next = PH_RX_LO;
            end
          end
          PH_MACK_LO: phase_next = PH_MACK_HI;
          PH_MACK_HI: begin
            if (bytes_left == '0) begin
              phase_next = PH_STOP_LO;
            end else begin
              shift_reg_next = 8'd0;
              bit_count_next = 4'd0;
              phase_next     = PH_RX_LO;
            end
          end
          PH_STOP_LO: phase_next = PH_STOP_HI;
          PH_STOP_HI: phase_next = PH_STOP_END;
          default:    phase_next = PH_IDLE;
        endcase
      end
    end
  end

  // outputs: line drive follows the updated state
  always_comb begin
    res = '0;
    res.busy_res = (phase_next != PH_IDLE);
    res.ack_bit  = ack_held_next;
    case (phase_next)
      PH_START_A: {res.scl_out, res.sda_out} = 2'b11;
      PH_START_B: {res.scl_out, res.sda_out} = 2'b10;
      PH_TX_LO:   {res.scl_out, res.sda_out} = {1'b0, |(shift_reg_next & MSB_MASK)};
      PH_TX_HI:   {res.scl_out, res.sda_out} = {1'b1, |(shift_reg_next & MSB_MASK)};
      PH_TACK_LO: {res.scl_out, res.sda_out} = 2'b01;
      PH_TACK_HI: {res.scl_out, res.sda_out} = 2'b11;
      PH_RX_LO:   {res.scl_out, res.sda_out} = 2'b01;
      PH_RX_HI:   {res.scl_out, res.sda_out} = 2'b11;
      PH_MACK_LO: {res.scl_out, res.sda_out} = {1'b0, bytes_left_next == '0};
      PH_MACK_HI: {res.scl_out, res.sda_out} = {1'b1, bytes_left_next == '0};
      PH_RS_LO:   {res.scl_out, res.sda_out} = 2'b01;
      PH_STOP_LO: {res.scl_out, res.sda_out} = 2'b00;
      PH_STOP_HI: {res.scl_out, res.sda_out} = 2'b10;
      default:    {res.scl_out, res.sda_out} = 2'b11;
    endcase
    if (rx_done) begin
      res.byte_valid = 1'b1;
      res.read_byte  = shift_reg_next;
      res.last_byte  = (bytes_left_next == '0);
      if (rx_odd) begin
        res.word_valid = 1'b1;
        res.read_word  = {held_high_byte, shift_reg_next};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      stage          <= ST_ADDR_W;
      tick_count     <= '0;
      bit_count      <= '0;
      shift_reg      <= '0;
      bytes_left     <= '0;
      held_high_byte <= '0;
      cmd_mode       <= '0;
      cmd_reg        <= '0;
      cmd_low        <= '0;
      ack_held       <= 1'b0;
    end else if (acc) begin
      phase          <= phase_next;
      stage          <= stage_next;
      tick_count     <= tick_count_next;
      bit_count      <= bit_count_next;
      shift_reg      <= shift_reg_next;
      bytes_left     <= bytes_left_next;
      held_high_byte <= held_high_byte_next;
      cmd_mode       <= cmd_mode_next;
      cmd_reg        <= cmd_reg_next;
      cmd_low        <= cmd_low_next;
      ack_held       <= ack_held_next;
    end
  end

`ifndef SYNTHESIS
  a_byte_from_rx: assert property (@(posedge clk) disable iff (rst)
    acc && res.byte_valid |-> phase == PH_RX_HI)
    else $error("received byte outside receive high half");
  a_word_has_byte: assert property (@(posedge clk) disable iff (rst)
    res.word_valid |-> res.byte_valid)
    else $error("word reported without its byte");
  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(bit_count) <= BITS_PER_BYTE)
    else $error("bit count past a byte");
  a_read_loads_burst: assert property (@(posedge clk) disable iff (rst)
    acc && phase == PH_IDLE && cmd.mode == MODE_READ |=>
      bytes_left != '0 && 32'(bytes_left) <= MAX_BURST)
    else $error("read burst length out of range");
`endif

endmodule

`default_nettype wire

// File: sv/i2cm_out_stage.sv
// result register with a skid entry so a word can be taken while the
// previous result waits downstream; depends on i2cm_pkg
`default_nettype none

module i2cm_out_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire i2cm_pkg::res_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output i2cm_pkg::res_t      out_data
);
  import i2cm_pkg::*;

  logic skid_valid;
  res_t skid_data;
  logic in_fire;
  logic out_free;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : in_data;
    end
    if (!out_free && in_fire) begin
      skid_data <= in_data;
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty result register");
  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_ready |=> out_valid && !skid_valid)
    else $error("skid entry not moved to result register");
  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && in_fire |=> skid_valid)
    else $error("word accepted under stall was not kept");
`endif

endmodule

`default_nettype wire

// File: sv/i2c_register_access_master_unit.sv
// i2c register access master: one word per bus tick in, one result word out.
// a result is registered in the output register, or in the skid entry on a stall.
// throughput: one word per cycle while the skid entry is empty.
// a skid entry takes one more word while the result side stalls.
// reset (synchronous): bus idle with both lines released, device address 104,
// half period 50 ticks, acknowledge bit 0; no clearing pass is needed.
`default_nettype none

module i2c_register_access_master_unit (
  input  wire logic clk,
  input  wire logic rst,
  i2cm_cmd_if.sink  cmd,
  i2cm_res_if.source res,
  i2cm_cfg_if.sink  cfg
);
  import i2cm_pkg::*;

  logic [6:0]  device_address;
  logic [15:0] half_period_ticks;
  logic        acc;
  res_t        step_res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address    <= DEVICE_ADDRESS_RST;
      half_period_ticks <= HALF_PERIOD_RST;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_DEVICE_ADDRESS: device_address    <= cfg.data.data[6:0];
        REG_HALF_PERIOD:    half_period_ticks <= cfg.data.data;
        default: ;
      endcase
    end
  end

  assign acc = cmd.valid && cmd.ready;

  i2cm_core u_core (
    .clk               (clk),
    .rst               (rst),
    .acc               (acc),
    .cmd               (cmd.data),
    .device_address    (device_address),
    .half_period_ticks (half_period_ticks),
    .res               (step_res)
  );

  i2cm_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .in_data   (step_res),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (res.data)
  );

endmodule

`default_nettype wire

// File: dv/i2cm_bus_checker.sv
// bus-level predictor and result comparison for the i2c register access master
// depends on i2cm_pkg and the cmd, res and cfg channel interfaces
module i2cm_bus_checker
  import i2cm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  i2cm_cmd_if       cmd,
  i2cm_res_if       res,
  i2cm_cfg_if       cfg,
  output int        mismatches,
  output int        in_flight,
  output logic      bus_idle,
  output int        cmds_started
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [6:0]         dev_addr;
  logic [15:0]        half_ticks;
  phase_t             ph;
  stage_t             stg;
  logic [15:0]        seg_ticks;
  logic [3:0]         bit_no;
  logic [7:0]         shifter;
  logic [BURST_W-1:0] left;
  logic [7:0]         high_byte;
  logic [1:0]         op;
  logic [7:0]         op_reg;
  logic [7:0]         op_low;
  logic               ack_seen;

  res_t predicted_lines[$];
  int   err_total = 0;
  int   started_total = 0;

  task automatic enter_phase(input phase_t p);
    ph = p;
    seg_ticks = '0;
  endtask

  task automatic load_byte();
    case (stg)
      ST_ADDR_W: shifter = {dev_addr, 1'b0};
      ST_REG:    shifter = op_reg;
      ST_DATA:   shifter = op_low;
      default:   shifter = {dev_addr, 1'b0} | READ_BIT;
    endcase
    bit_no = '0;
    enter_phase(PH_TX_LO);
  endtask

  // {scl, sda} as driven in the current phase
  function automatic logic [1:0] line_levels();
    case (ph)
      PH_START_A:                    return 2'b11;
      PH_START_B:                    return 2'b10;
      PH_TX_LO:                      return {1'b0, shifter[7]};
      PH_TX_HI:                      return {1'b1, shifter[7]};
      PH_TACK_LO, PH_RX_LO, PH_RS_LO: return 2'b01;
      PH_TACK_HI, PH_RX_HI:          return 2'b11;
      PH_MACK_LO:                    return {1'b0, left == '0};
      PH_MACK_HI:                    return {1'b1, left == '0};
      PH_STOP_LO:                    return 2'b00;
      PH_STOP_HI:                    return 2'b10;
      default:                       return 2'b11;
    endcase
  endfunction

  task automatic advance_bus(input cmd_t w, output res_t r);
    logic [7:0]         idx;
    logic [BURST_W-1:0] rc;
    logic [1:0]         lv;
    r = '0;
    if (ph == PH_IDLE) begin
      if (w.mode == MODE_WRITE || w.mode == MODE_READ) begin
        op = w.mode;
        op_reg = w.reg_addr;
        op_low = w.write_data;
        if (w.mode == MODE_READ) begin
          rc = w.read_count;
          if (rc == '0) rc = BURST_W'(1);
          if (rc > BURST_W'(MAX_BURST)) rc = BURST_W'(MAX_BURST);
          op_low = 8'(rc);
          left = rc;
        end
        stg = ST_ADDR_W;
        enter_phase(PH_START_A);
        started_total++;
      end
    end else begin
      seg_ticks = seg_ticks + 16'd1;
      // a lowered half period ends a running segment at once
      if (seg_ticks >= half_ticks) begin
        case (ph)
          PH_START_A: enter_phase(PH_START_B);
          PH_START_B: load_byte();
          PH_TX_LO:   enter_phase(PH_TX_HI);
          PH_TX_HI: begin
            shifter = shifter << 1;
            bit_no++;
            if (bit_no >= 4'(BITS_PER_BYTE)) enter_phase(PH_TACK_LO);
            else enter_phase(PH_TX_LO);
          end
          PH_TACK_LO: enter_phase(PH_TACK_HI);
          PH_TACK_HI: begin
            ack_seen = w.sda_in;
            case (stg)
              ST_ADDR_W: begin
                stg = ST_REG;
                load_byte();
              end
              ST_REG: begin
                if (op == MODE_WRITE) begin
                  stg = ST_DATA;
                  load_byte();
                end else begin
                  enter_phase(PH_RS_LO);
                end
              end
              ST_DATA: enter_phase(PH_STOP_LO);
              default: begin
                shifter = '0;
                bit_no = '0;
                enter_phase(PH_RX_LO);
              end
            endcase
          end
          PH_RS_LO: begin
            stg = ST_ADDR_R;
            enter_phase(PH_START_A);
          end
          PH_RX_LO: enter_phase(PH_RX_HI);
          PH_RX_HI: begin
            shifter = {shifter[6:0], w.sda_in};
            bit_no++;
            if (bit_no >= 4'(BITS_PER_BYTE)) begin
              // odd byte index closes a big-endian pair
              idx = op_low - 8'(left);
              r.byte_valid = 1'b1;
              r.read_byte = shifter;
              if (idx[0]) begin
                r.word_valid = 1'b1;
                r.read_word = {high_byte, shifter};
              end else begin
                high_byte = shifter;
              end
              if (left != '0) left--;
              r.last_byte = (left == '0);
              enter_phase(PH_MACK_LO);
            end else begin
              enter_phase(PH_RX_LO);
            end
          end
          PH_MACK_LO: enter_phase(PH_MACK_HI);
          PH_MACK_HI: begin
            if (left == '0) begin
              enter_phase(PH_STOP_LO);
            end else begin
              shifter = '0;
              bit_no = '0;
              enter_phase(PH_RX_LO);
            end
          end
          PH_STOP_LO: enter_phase(PH_STOP_HI);
          PH_STOP_HI: enter_phase(PH_STOP_END);
          default:    enter_phase(PH_IDLE);
        endcase
      end
    end
    lv = line_levels();
    r.scl_out  = lv[1];
    r.sda_out  = lv[0];
    r.busy_res = (ph != PH_IDLE);
    r.ack_bit  = ack_seen;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_total++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    res_t seen;
    res_t want;
    if (rst) begin
      dev_addr   = DEVICE_ADDRESS_RST;
      half_ticks = HALF_PERIOD_RST;
      ph         = PH_IDLE;
      stg        = ST_ADDR_W;
      seg_ticks  = '0;
      bit_no     = '0;
      shifter    = '0;
      left       = '0;
      high_byte  = '0;
      op         = '0;
      op_reg     = '0;
      op_low     = '0;
      ack_seen   = 1'b0;
      predicted_lines.delete();
    end else begin
      // compare before pushing so a word never meets its own prediction
      if (res.valid && res.ready) begin
        seen = res.data;
        if (predicted_lines.size() == 0) begin
          err_total++;
          $display("%0t ns: result word with nothing expected, actual %0h", $time, seen);
        end else begin
          want = predicted_lines.pop_front();
          check_field("scl_out", want.scl_out, seen.scl_out);
          check_field("sda_out", want.sda_out, seen.sda_out);
          check_field("busy_res", want.busy_res, seen.busy_res);
          check_field("byte_valid", want.byte_valid, seen.byte_valid);
          check_field("read_byte", want.read_byte, seen.read_byte);
          check_field("word_valid", want.word_valid, seen.word_valid);
          check_field("read_word", want.read_word, seen.read_word);
          check_field("ack_bit", want.ack_bit, seen.ack_bit);
          check_field("last_byte", want.last_byte, seen.last_byte);
        end
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.data.index == REG_DEVICE_ADDRESS) dev_addr = cfg.data.data[6:0];
        else half_ticks = cfg.data.data;
      end
      if (cmd.valid && cmd.ready) begin
        advance_bus(cmd.data, want);
        predicted_lines.push_back(want);
      end
    end
    mismatches   <= err_total;
    in_flight    <= predicted_lines.size();
    bus_idle     <= (ph == PH_IDLE);
    cmds_started <= started_total;
  end

endmodule

// File: dv/tb_i2c_register_access_master_unit.sv
// top of the i2c register access master testbench: clock, reset, stimulus, verdict
// depends on i2cm_pkg, the channel interfaces, the block and i2cm_bus_checker
module tb_i2c_register_access_master_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 125;
  localparam int LONG_HOLD       = 200;
  localparam longint RUN_LIMIT_NS = 64'd10_000_000;

  logic clk;
  logic rst;
  logic random_part;
  bit   steady_feed;

  int   mismatches;
  int   in_flight;
  int   cmds_started;
  logic bus_idle;

  i2cm_cmd_if cmd_ch ();
  i2cm_res_if res_ch ();
  i2cm_cfg_if cfg_ch ();

  i2c_register_access_master_unit dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  i2cm_bus_checker bus_chk (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd_ch),
    .res          (res_ch),
    .cfg          (cfg_ch),
    .mismatches   (mismatches),
    .in_flight    (in_flight),
    .bus_idle     (bus_idle),
    .cmds_started (cmds_started)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("** i2c_register_access_master_unit: FAILED **");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic cmd_t random_word();
    cmd_t w;
    int   roll;
    w.reg_addr   = 8'($urandom);
    w.write_data = 8'($urandom);
    w.sda_in     = 1'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 55) w.mode = MODE_NONE;
    else if (roll < 70) w.mode = MODE_WRITE;
    else if (roll < 95) w.mode = MODE_READ;
    else w.mode = MODE_UNUSED;
    roll = $urandom_range(0, 99);
    if (roll < 70) w.read_count = 5'($urandom_range(1, 4));
    else if (roll < 85) w.read_count = 5'($urandom_range(5, 16));
    else if (roll < 95) w.read_count = 5'($urandom_range(17, 31));
    else w.read_count = '0;
    return w;
  endfunction

  task automatic send_word(input cmd_t w);
    int gap;
    gap = steady_feed ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= w;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [6:0] dev, input logic [15:0] ticks);
    cfg_t c;
    for (int i = 0; i < 2; i++) begin
      c.index = (i == 0) ? REG_DEVICE_ADDRESS : REG_HALF_PERIOD;
      c.data  = (i == 0) ? {9'd0, dev} : ticks;
      cfg_ch.valid <= 1'b1;
      cfg_ch.data  <= c;
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // offer until the bus takes it; the copy that follows lands while busy
  task automatic start_command(input logic [1:0] mode, input logic [7:0] reg_addr,
                               input logic [7:0] data, input logic [4:0] count);
    cmd_t w;
    int   seen_before;
    seen_before = cmds_started;
    w = random_word();
    w.mode       = mode;
    w.reg_addr   = reg_addr;
    w.write_data = data;
    w.read_count = count;
    while (cmds_started == seen_before) send_word(w);
  endtask

  task automatic idle_ticks_until_free();
    cmd_t w;
    while (!bus_idle) begin
      w = random_word();
      w.mode = MODE_NONE;
      send_word(w);
    end
  endtask

  task automatic run_command(input logic [1:0] mode, input logic [7:0] reg_addr,
                             input logic [7:0] data, input logic [4:0] count);
    start_command(mode, reg_addr, data, count);
    idle_ticks_until_free();
  endtask

  initial begin : result_side
    int gap;
    bit long_hold_done;
    long_hold_done = 1'b0;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (random_part && !long_hold_done) begin
        long_hold_done = 1'b1;
        gap = LONG_HOLD;
      end else begin
        gap = pick_gap();
      end
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  initial begin : stimulus
    cmd_t w;
    rst          <= 1'b1;
    random_part  <= 1'b0;
    steady_feed  = 1'b0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.data  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, both operations, ignored modes, burst corners
    write_cfg(7'h7F, 16'd1);
    run_command(MODE_WRITE, 8'h00, 8'hFF, 5'd0);
    run_command(MODE_WRITE, 8'hFF, 8'h00, 5'd31);
    w = random_word();
    w.mode = MODE_UNUSED;
    send_word(w);
    w.mode = MODE_NONE;
    send_word(w);
    run_command(MODE_READ, 8'hA5, 8'h00, 5'd0);
    run_command(MODE_READ, 8'h5A, 8'h00, 5'd3);
    run_command(MODE_READ, 8'h3C, 8'h00, 5'd2);
    drain();
    write_cfg(7'h00, 16'd0);
    run_command(MODE_READ, 8'h01, 8'h00, 5'd31);
    run_command(MODE_WRITE, 8'h80, 8'h55, 5'd16);

    // longest half period, then cut it short in the middle of a segment
    drain();
    write_cfg(DEVICE_ADDRESS_RST, 16'hFFFF);
    start_command(MODE_READ, 8'hC3, 8'h00, 5'd2);
    repeat (20) begin
      w = random_word();
      w.mode = MODE_NONE;
      send_word(w);
    end
    drain();
    write_cfg(DEVICE_ADDRESS_RST, 16'd2);
    idle_ticks_until_free();

    // random phases; a config change may land mid-transaction on the bus
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      write_cfg(7'($urandom), 16'($urandom_range(0, 3)));
      random_part <= 1'b1;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (n % 50 == 0) steady_feed = ($urandom_range(0, 3) == 0);
        send_word(random_word());
      end
    end
    steady_feed = 1'b0;

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("** i2c_register_access_master_unit: PASSED **");
    end else begin
      $display("** i2c_register_access_master_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/i2cm_pkg.sv
sv/i2cm_cmd_if.sv
sv/i2cm_res_if.sv
sv/i2cm_cfg_if.sv
sv/i2cm_core.sv
sv/i2cm_out_stage.sv
sv/i2c_register_access_master_unit.sv
dv/i2cm_bus_checker.sv
dv/tb_i2c_register_access_master_unit.sv
